// ----- src/slad_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and control structs of the lookahead anomaly detector.
package slad_pkg;

  localparam int NUM_SYSCALLS = 512;
  localparam int WINDOW_LEN   = 9;

  localparam int SC_IN_W     = 12;
  localparam int TS_W        = 64;
  localparam int CNT_W       = 32;
  localparam int MISM_W      = 4;
  localparam int LIMIT_W     = 16;
  localparam int FACTOR_W    = 10;
  localparam int WAIT_W      = 50;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 50;

  localparam int FLAG_W      = WINDOW_LEN - 1;
  localparam int FLAG_DEPTH  = NUM_SYSCALLS * NUM_SYSCALLS;
  localparam int FLAG_AW     = $clog2(FLAG_DEPTH);
  localparam int SC_W        = $clog2(NUM_SYSCALLS);
  localparam int SLOT_W      = $clog2(WINDOW_LEN);
  localparam int BIT_W       = (FLAG_W > 1) ? $clog2(FLAG_W) : 1;
  localparam int PROD_W      = CNT_W + FACTOR_W;

  localparam logic               RST_MONITOR_ENABLE     = 1'b1;
  localparam logic               RST_SAVE_IN_PROGRESS   = 1'b0;
  localparam logic               RST_PROCESS_ASSOCIATED = 1'b1;
  localparam logic [LIMIT_W-1:0] RST_ANOMALY_LIMIT      = 16'd30;
  localparam logic [FACTOR_W-1:0] RST_NORMAL_FACTOR     = 10'd128;
  localparam logic [FACTOR_W-1:0] RST_NORMAL_FACTOR_DEN = 10'd32;
  localparam logic [WAIT_W-1:0]  RST_NORMAL_WAIT        = 50'd604800000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MONITOR_ENABLE     = 3'd0,
    CFG_SAVE_IN_PROGRESS   = 3'd1,
    CFG_PROCESS_ASSOCIATED = 3'd2,
    CFG_ANOMALY_LIMIT      = 3'd3,
    CFG_NORMAL_FACTOR      = 3'd4,
    CFG_NORMAL_FACTOR_DEN  = 3'd5,
    CFG_NORMAL_WAIT        = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SC_IN_W-1:0] syscall_number;
    logic [TS_W-1:0]    timestamp_ns;
  } in_item_t;

  typedef struct packed {
    logic              ignored;
    logic [MISM_W-1:0] mismatch_count;
    logic              anomaly_reported;
    logic [CNT_W-1:0]  anomaly_total;
    logic              profile_updated;
    logic              is_normal;
    logic              is_frozen;
    logic              entered_normal;
    logic              left_normal;
  } out_item_t;

  // Commands from the controller to the datapath; at most one is high per cycle.
  typedef struct packed {
    logic clear;
    logic accept;
    logic issue_cnt;
    logic issue_set;
    logic eval;
    logic calc_nc;
    logic calc_mul;
    logic freeze;
    logic check_dl;
    logic load_out;
  } slad_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic item_ignored;
    logic pass_end;
    logic mism_any;
  } slad_status_t;

endpackage

// ----- src/slad_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences the clear pass, the flag passes and the profile update.
module slad_ctrl
  import slad_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  slad_status_t status_i,
  output slad_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT,
    S_CNT_TAIL,
    S_EVAL,
    S_SET,
    S_SET_TAIL,
    S_NC,
    S_MUL,
    S_FRZ,
    S_DL,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.item_ignored ? S_DONE : S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.issue_cnt = 1'b1;
        if (status_i.pass_end) begin
          state_d = S_CNT_TAIL;
        end
      end
      S_CNT_TAIL: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = status_i.mism_any ? S_SET : S_NC;
      end
      S_SET: begin
        cmd_o.issue_set = 1'b1;
        if (status_i.pass_end) begin
          state_d = S_SET_TAIL;
        end
      end
      S_SET_TAIL: state_d = S_DL;
      S_NC: begin
        cmd_o.calc_nc = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d = S_FRZ;
      end
      S_FRZ: begin
        cmd_o.freeze = 1'b1;
        state_d = S_DL;
      end
      S_DL: begin
        cmd_o.check_dl = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/slad_dp.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, call window, flag memory and profile counters.
module slad_dp
  import slad_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_item_i,
  input  slad_cmd_t             cmd_i,
  output slad_status_t          status_o,
  output out_item_t             out_item_o
);

  // Configuration registers
  logic                mon_en_q, save_q, assoc_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [FACTOR_W-1:0] factor_q, factor_den_q;
  logic [WAIT_W-1:0]   wait_q;

  // Profile state
  logic [SC_IN_W-1:0]    win_q [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] win_vld_q;
  logic                  normal_q, frozen_q;
  logic [CNT_W-1:0]      train_q, lc_q, anom_q;
  logic [TS_W-1:0]       deadline_q;

  // Pass control
  logic [SLOT_W-1:0]  slot_q;
  logic [FLAG_AW-1:0] clr_cnt_q;
  logic               rd_pend_q, rd_set_q, rd_chk_q, fwd_q;
  logic [BIT_W-1:0]   rd_bit_q;
  logic [FLAG_AW-1:0] rd_addr_q;
  logic [FLAG_W-1:0]  fwd_data_q;

  // Item and arithmetic registers
  logic [TS_W-1:0]   now_q;
  logic [MISM_W-1:0] mism_q;
  logic              ignored_q, reported_q, updated_q, entered_q, left_q;
  logic [CNT_W-1:0]  nc_q;
  logic [PROD_W-1:0] prod_tc_q, prod_nc_q;
  logic [TS_W:0]     dl_sum_q;
  out_item_t         out_q;

  // Flag memory
  logic [FLAG_W-1:0]  flags_mem [FLAG_DEPTH];
  logic [FLAG_W-1:0]  mem_rdata_q;
  logic               mem_we, mem_re;
  logic [FLAG_AW-1:0] mem_waddr;
  logic [FLAG_W-1:0]  mem_wdata;

  logic               ignore_now;
  logic [SC_IN_W-1:0] cur_sc, prev_sc;
  logic               cur_in, prev_in, issue_ok, issue_en;
  logic [FLAG_AW-1:0] iss_addr;
  logic [FLAG_W-1:0]  rdata_eff, set_wdata;
  logic               proc_set, proc_cnt, hit;
  logic               reported, left_now;
  logic [CNT_W:0]     anom_sum;
  logic               freeze_go, enter_go;

  function automatic logic [FLAG_AW-1:0] flag_addr(input logic [SC_IN_W-1:0] cur,
                                                   input logic [SC_IN_W-1:0] prev);
    logic [FLAG_AW-1:0] row;
    row = FLAG_AW'(cur[SC_W-1:0]) * FLAG_AW'(NUM_SYSCALLS);
    return row + FLAG_AW'(prev[SC_W-1:0]);
  endfunction

  assign ignore_now = !assoc_q || save_q || !mon_en_q;

  assign cur_sc   = win_q[0];
  assign prev_sc  = win_q[slot_q];
  assign cur_in   = (cur_sc < SC_IN_W'(NUM_SYSCALLS));
  assign prev_in  = (prev_sc < SC_IN_W'(NUM_SYSCALLS));
  assign iss_addr = flag_addr(cur_sc, prev_sc);

  // Testing skips out-of-table pairs, training stops at the first one.
  assign issue_ok = win_vld_q[slot_q] && (cmd_i.issue_set ? (cur_in && prev_in) : 1'b1);
  assign issue_en = (cmd_i.issue_cnt || cmd_i.issue_set) && issue_ok;

  // A write of the previous slot to the same byte is not yet visible in the read data.
  assign rdata_eff = fwd_q ? fwd_data_q : mem_rdata_q;
  assign hit       = rdata_eff[rd_bit_q];
  assign set_wdata = rdata_eff | (FLAG_W'(1) << rd_bit_q);
  assign proc_set  = rd_pend_q && rd_set_q;
  assign proc_cnt  = rd_pend_q && !rd_set_q;

  assign mem_re    = issue_en && cur_in && prev_in;
  assign mem_we    = cmd_i.clear || proc_set;
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : rd_addr_q;
  assign mem_wdata = cmd_i.clear ? '0 : set_wdata;

  assign reported  = normal_q && (mism_q != '0);
  assign left_now  = reported && (anom_q > CNT_W'(limit_q));
  assign anom_sum  = {1'b0, anom_q} + (CNT_W + 1)'(mism_q);
  assign freeze_go = !frozen_q && (nc_q != '0) && (prod_tc_q > prod_nc_q);
  assign enter_go  = frozen_q && (now_q > deadline_q);

  assign status_o.clear_last   = (clr_cnt_q == FLAG_AW'(FLAG_DEPTH - 1));
  assign status_o.item_ignored = ignore_now;
  assign status_o.pass_end     = !issue_ok || (slot_q == SLOT_W'(WINDOW_LEN - 1));
  assign status_o.mism_any     = (mism_q != '0);

  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flags_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= flags_mem[iss_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_en_q     <= RST_MONITOR_ENABLE;
      save_q       <= RST_SAVE_IN_PROGRESS;
      assoc_q      <= RST_PROCESS_ASSOCIATED;
      limit_q      <= RST_ANOMALY_LIMIT;
      factor_q     <= RST_NORMAL_FACTOR;
      factor_den_q <= RST_NORMAL_FACTOR_DEN;
      wait_q       <= RST_NORMAL_WAIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MONITOR_ENABLE:     mon_en_q     <= cfg_data_i[0];
        CFG_SAVE_IN_PROGRESS:   save_q       <= cfg_data_i[0];
        CFG_PROCESS_ASSOCIATED: assoc_q      <= cfg_data_i[0];
        CFG_ANOMALY_LIMIT:      limit_q      <= cfg_data_i[LIMIT_W-1:0];
        CFG_NORMAL_FACTOR:      factor_q     <= cfg_data_i[FACTOR_W-1:0];
        CFG_NORMAL_FACTOR_DEN:  factor_den_q <= cfg_data_i[FACTOR_W-1:0];
        CFG_NORMAL_WAIT:        wait_q       <= cfg_data_i[WAIT_W-1:0];
        default: ;
      endcase
    end else if (cmd_i.accept && assoc_q && save_q) begin
      // A save underway switches monitoring off until software turns it back on.
      mon_en_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      slot_q    <= SLOT_W'(1);
      rd_pend_q <= 1'b0;
      rd_set_q  <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + FLAG_AW'(1);
      end
      if (cmd_i.accept || cmd_i.eval) begin
        slot_q <= SLOT_W'(1);
      end else if (issue_en) begin
        slot_q <= slot_q + SLOT_W'(1);
      end
      rd_pend_q <= issue_en;
      rd_set_q  <= cmd_i.issue_set;
      fwd_q     <= proc_set && issue_en && (iss_addr == rd_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      rd_chk_q  <= cur_in && prev_in;
      rd_bit_q  <= BIT_W'(slot_q - SLOT_W'(1));
      rd_addr_q <= iss_addr;
    end
    fwd_data_q <= set_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      win_vld_q  <= '0;
      normal_q   <= 1'b0;
      frozen_q   <= 1'b0;
      train_q    <= '0;
      lc_q       <= '0;
      anom_q     <= '0;
      deadline_q <= '0;
    end else begin
      if (cmd_i.accept && !ignore_now) begin
        for (int i = WINDOW_LEN - 1; i > 0; i--) begin
          win_q[i] <= win_q[i-1];
        end
        win_q[0]  <= in_item_i.syscall_number;
        win_vld_q <= {win_vld_q[WINDOW_LEN-2:0], 1'b1};
      end
      if (cmd_i.eval) begin
        if (left_now) begin
          normal_q <= 1'b0;
        end
        if (reported) begin
          anom_q <= anom_sum[CNT_W] ? '1 : anom_sum[CNT_W-1:0];
        end
        if (train_q != '1) begin
          train_q <= train_q + CNT_W'(1);
        end
        if (mism_q != '0) begin
          frozen_q <= 1'b0;
          lc_q     <= '0;
        end else if (lc_q != '1) begin
          lc_q <= lc_q + CNT_W'(1);
        end
      end
      if (cmd_i.freeze && freeze_go) begin
        frozen_q   <= 1'b1;
        deadline_q <= dl_sum_q[TS_W] ? '1 : dl_sum_q[TS_W-1:0];
      end
      if (cmd_i.check_dl && enter_go) begin
        normal_q <= 1'b1;
        frozen_q <= 1'b0;
        anom_q   <= '0;
        lc_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q      <= in_item_i.timestamp_ns;
      ignored_q  <= ignore_now;
      mism_q     <= '0;
      reported_q <= 1'b0;
      updated_q  <= 1'b0;
      entered_q  <= 1'b0;
      left_q     <= 1'b0;
    end else begin
      if (proc_cnt && rd_chk_q && !hit) begin
        mism_q <= mism_q + MISM_W'(1);
      end
      if (proc_set && !hit) begin
        updated_q <= 1'b1;
      end
      if (cmd_i.eval) begin
        reported_q <= reported;
        left_q     <= left_now;
      end
      if (cmd_i.check_dl && enter_go) begin
        entered_q <= 1'b1;
      end
    end
    if (cmd_i.calc_nc) begin
      nc_q <= (lc_q > train_q) ? '0 : train_q - lc_q;
    end
    if (cmd_i.calc_mul) begin
      prod_tc_q <= PROD_W'(train_q) * PROD_W'(factor_den_q);
      prod_nc_q <= PROD_W'(nc_q) * PROD_W'(factor_q);
      dl_sum_q  <= {1'b0, now_q} + (TS_W + 1)'(wait_q);
    end
    if (cmd_i.load_out) begin
      out_q.ignored          <= ignored_q;
      out_q.mismatch_count   <= mism_q;
      out_q.anomaly_reported <= reported_q;
      out_q.anomaly_total    <= anom_q;
      out_q.profile_updated  <= updated_q;
      out_q.is_normal        <= normal_q;
      out_q.is_frozen        <= frozen_q;
      out_q.entered_normal   <= entered_q;
      out_q.left_normal      <= left_q;
    end
  end

endmodule

// ----- src/syscall_lookahead_anomaly_detector_unit.sv -----
`timescale 1ns / 1ps
// Top level of the lookahead-pair system call anomaly detector.
//
// Each input item carries one system call number and a timestamp of the traced
// process; each accepted item yields exactly one result item on the output
// channel. Both channels use valid/stall: an item moves on a clock edge where
// valid is high and stall is low. Configuration registers are written through
// the cfg port (index and data, valid/ready; ready is always high); the user
// must write them only while the block is idle; the block does not enforce it.
// An ignored item goes from acceptance straight to S_DONE, where its result is
// loaded. Otherwise the flag memory is visited once per earlier call to count
// mismatches and, when there were any, once more to set the missing bits; the
// freeze test adds a multiply stage. One item is worked on at a time, and the
// next one can be accepted in the cycle after the result is loaded.
// After reset the flag memory is swept to zero, one byte per cycle
// (NUM_SYSCALLS*NUM_SYSCALLS = 262144 bytes); in_stall_o stays high meanwhile.
// A finished result sits in an output register until taken; when the receiver
// stalls, the next item is still accepted and processed, and only its final
// transfer waits.
module syscall_lookahead_anomaly_detector_unit
  import slad_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  slad_cmd_t    cmd;
  slad_status_t status;

  assign cfg_ready_o = 1'b1;

  slad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  slad_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- test/slad_result_check.sv -----
`timescale 1ns / 1ps
// Result checker for the lookahead anomaly detector: predicts and compares every result item.
module slad_result_check
  import slad_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam bit [TS_W-1:0] TS_MAX = '1;

  // Profile state as the block should hold it.
  bit [FLAG_W-1:0]     pair_flags [FLAG_DEPTH];
  bit [SC_IN_W-1:0]    recent_calls [WINDOW_LEN];
  bit [WINDOW_LEN-1:0] filled;
  bit                  normal_q;
  bit                  frozen_q;
  bit [CNT_W-1:0]      trained;
  bit [CNT_W-1:0]      since_change;
  bit [CNT_W-1:0]      anomalies;
  bit [TS_W-1:0]       deadline;

  bit                  monitor_on = RST_MONITOR_ENABLE;
  bit                  saving     = RST_SAVE_IN_PROGRESS;
  bit                  bound      = RST_PROCESS_ASSOCIATED;
  bit [LIMIT_W-1:0]    limit      = RST_ANOMALY_LIMIT;
  bit [FACTOR_W-1:0]   factor     = RST_NORMAL_FACTOR;
  bit [FACTOR_W-1:0]   factor_den = RST_NORMAL_FACTOR_DEN;
  bit [WAIT_W-1:0]     wait_ns    = RST_NORMAL_WAIT;

  out_item_t verdicts [$];
  out_item_t oldest;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  function automatic bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic out_item_t judge_call(in_item_t it);
    out_item_t       r;
    int unsigned     cur;
    int unsigned     prev;
    int unsigned     spot;
    int unsigned     misses;
    int unsigned     i;
    bit              skip;
    bit              changed;
    bit              reported;
    bit              entered;
    bit              left_now;
    longint unsigned total;
    longint unsigned lhs;
    longint unsigned rhs;
    longint unsigned unchanged;
    bit [TS_W-1:0]   now;

    r        = '0;
    misses   = 0;
    changed  = 1'b0;
    reported = 1'b0;
    entered  = 1'b0;
    left_now = 1'b0;
    now      = it.timestamp_ns;

    // A save in progress switches monitoring off for good, until rewritten.
    skip = 1'b1;
    if (bound) begin
      if (saving) monitor_on = 1'b0;
      if (monitor_on) skip = 1'b0;
    end

    if (!skip) begin
      for (i = WINDOW_LEN - 1; i > 0; i--) recent_calls[i] = recent_calls[i-1];
      recent_calls[0] = it.syscall_number;
      filled = {filled[WINDOW_LEN-2:0], 1'b1};
      cur = 32'(recent_calls[0]);

      // Out-of-table earlier calls are skipped here but end training below.
      for (i = 1; i < WINDOW_LEN; i++) begin
        if (!filled[i]) break;
        prev = 32'(recent_calls[i]);
        if (cur < NUM_SYSCALLS && prev < NUM_SYSCALLS &&
            !pair_flags[cur * NUM_SYSCALLS + prev][i-1]) misses++;
      end

      if (normal_q && misses != 0) begin
        reported = 1'b1;
        if (anomalies > limit) begin
          normal_q = 1'b0;
          left_now = 1'b1;
        end
      end
      if (reported) begin
        total = 64'(anomalies) + 64'(misses);
        anomalies = (total > 64'hFFFF_FFFF) ? '1 : total[CNT_W-1:0];
      end

      trained = bump(trained);
      if (misses != 0) begin
        frozen_q = 1'b0;
        for (i = 1; i < WINDOW_LEN; i++) begin
          prev = 32'(recent_calls[i]);
          if (!filled[i] || cur >= NUM_SYSCALLS || prev >= NUM_SYSCALLS) break;
          spot = cur * NUM_SYSCALLS + prev;
          if (!pair_flags[spot][i-1]) begin
            pair_flags[spot][i-1] = 1'b1;
            changed = 1'b1;
          end
        end
        since_change = '0;
      end else begin
        since_change = bump(since_change);
        if (!frozen_q) begin
          unchanged = (since_change > trained) ? 64'd0 : 64'(trained - since_change);
          lhs = 64'(trained);
          lhs *= 64'(factor_den);
          rhs = unchanged;
          rhs *= 64'(factor);
          if (unchanged != 0 && lhs > rhs) begin
            frozen_q = 1'b1;
            deadline = (now > TS_MAX - 64'(wait_ns)) ? TS_MAX : now + 64'(wait_ns);
          end
        end
      end

      if (frozen_q && now > deadline) begin
        normal_q     = 1'b1;
        frozen_q     = 1'b0;
        anomalies    = '0;
        since_change = '0;
        entered      = 1'b1;
      end
    end

    r.ignored          = skip;
    r.mismatch_count   = misses[MISM_W-1:0];
    r.anomaly_reported = reported;
    r.anomaly_total    = anomalies;
    r.profile_updated  = changed;
    r.is_normal        = normal_q;
    r.is_frozen        = frozen_q;
    r.entered_normal   = entered;
    r.left_normal      = left_now;
    return r;
  endfunction

  task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, label, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MONITOR_ENABLE:     monitor_on = cfg_data_i[0];
          CFG_SAVE_IN_PROGRESS:   saving     = cfg_data_i[0];
          CFG_PROCESS_ASSOCIATED: bound      = cfg_data_i[0];
          CFG_ANOMALY_LIMIT:      limit      = cfg_data_i[LIMIT_W-1:0];
          CFG_NORMAL_FACTOR:      factor     = cfg_data_i[FACTOR_W-1:0];
          CFG_NORMAL_FACTOR_DEN:  factor_den = cfg_data_i[FACTOR_W-1:0];
          CFG_NORMAL_WAIT:        wait_ns    = cfg_data_i[WAIT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (verdicts.size() == 0) begin
          $display("%0t: result item %h arrived with no item outstanding", $time, out_item_i);
          mismatches_o++;
        end else begin
          oldest = verdicts.pop_front();
          check_field("ignored", 64'(oldest.ignored), 64'(out_item_i.ignored));
          check_field("mismatch_count", 64'(oldest.mismatch_count),
                      64'(out_item_i.mismatch_count));
          check_field("anomaly_reported", 64'(oldest.anomaly_reported),
                      64'(out_item_i.anomaly_reported));
          check_field("anomaly_total", 64'(oldest.anomaly_total),
                      64'(out_item_i.anomaly_total));
          check_field("profile_updated", 64'(oldest.profile_updated),
                      64'(out_item_i.profile_updated));
          check_field("is_normal", 64'(oldest.is_normal), 64'(out_item_i.is_normal));
          check_field("is_frozen", 64'(oldest.is_frozen), 64'(out_item_i.is_frozen));
          check_field("entered_normal", 64'(oldest.entered_normal),
                      64'(out_item_i.entered_normal));
          check_field("left_normal", 64'(oldest.left_normal), 64'(out_item_i.left_normal));
        end
      end

      if (in_valid_i && !in_stall_i) verdicts.push_back(judge_call(in_item_i));
      pending_o = verdicts.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the lookahead anomaly detector: clock, reset, stimulus and verdict.
module testbench;
  import slad_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 3 * FLAG_DEPTH;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned SC_TOP        = (1 << SC_IN_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam logic [WAIT_W-1:0]    WAIT_MAX      = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          mismatches;
  int          pending;
  int unsigned quiet_cycles;
  logic [TS_W-1:0] clock_ns;
  bit          steady;
  bit          squeeze_req;
  bit          squeeze_done;
  int          k;

  syscall_lookahead_anomaly_detector_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  slad_result_check result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The flag sweep after reset keeps the input stalled for a long time, so the
  // limit on quiet cycles sits well above it.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while steady.
  initial begin
    out_stall_i  = 1'b0;
    squeeze_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        squeeze_done = 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(0, 99) < 17);
      end
    end
  end

  task automatic send_call(logic [SC_IN_W-1:0] sc, logic [TS_W-1:0] ts);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= {sc, ts};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every result has been taken.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup_profile(bit mon, bit save, bit assoc, logic [LIMIT_W-1:0] limit,
                               logic [FACTOR_W-1:0] factor, logic [FACTOR_W-1:0] den,
                               logic [WAIT_W-1:0] wait_ns);
    drain;
    write_reg(CFG_MONITOR_ENABLE, CFG_DATA_W'(mon));
    write_reg(CFG_SAVE_IN_PROGRESS, CFG_DATA_W'(save));
    write_reg(CFG_PROCESS_ASSOCIATED, CFG_DATA_W'(assoc));
    write_reg(CFG_ANOMALY_LIMIT, CFG_DATA_W'(limit));
    write_reg(CFG_NORMAL_FACTOR, CFG_DATA_W'(factor));
    write_reg(CFG_NORMAL_FACTOR_DEN, CFG_DATA_W'(den));
    write_reg(CFG_NORMAL_WAIT, CFG_DATA_W'(wait_ns));
  endtask

  // Mostly a repeating loop of calls, as a real program makes, broken up by
  // restarts, new loops, novel or out-of-table calls and jumps in time.
  task automatic run_traffic(int unsigned count, int unsigned noise_pct, int unsigned max_step);
    logic [SC_IN_W-1:0] loop_calls [6];
    logic [SC_IN_W-1:0] sc;
    int unsigned        loop_len;
    int unsigned        pos;
    int unsigned        n;
    int unsigned        j;
    int unsigned        roll;

    loop_len = 0;
    pos      = 0;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (loop_len == 0 || roll < 2) begin
        loop_len = $urandom_range(2, 6);
        for (j = 0; j < loop_len; j++) begin
          loop_calls[j] = SC_IN_W'($urandom_range(0, NUM_SYSCALLS - 1));
        end
        pos = 0;
      end else if (roll < 4) begin
        pos = 0;
      end
      if (roll >= 100 - noise_pct) begin
        sc = ($urandom_range(0, 3) == 0) ? SC_IN_W'($urandom_range(NUM_SYSCALLS, SC_TOP))
                                         : SC_IN_W'($urandom_range(0, NUM_SYSCALLS - 1));
      end else begin
        sc  = loop_calls[pos];
        pos = (pos + 1) % loop_len;
      end
      if ($urandom_range(0, 99) == 0) clock_ns = {$urandom, $urandom};
      else clock_ns += TS_W'($urandom_range(0, max_step));
      send_call(sc, clock_ns);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    clock_ns    = '0;
    steady      = 1'b0;
    squeeze_req = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A two-call loop trains, freezes and turns normal; novel calls then
    // raise anomalies and end normal mode, interleaved with out-of-table calls.
    setup_profile(1'b1, 1'b0, 1'b1, 0, 1, 2, 5);
    for (k = 0; k < 13; k++) begin
      send_call(SC_IN_W'((k % 2) ? NUM_SYSCALLS - 1 : 0), TS_W'(3 * k));
    end
    send_call(300, 39);
    send_call(SC_IN_W'(SC_TOP), 42);
    send_call(301, 45);
    send_call(SC_IN_W'(NUM_SYSCALLS), 48);
    send_call(SC_IN_W'(NUM_SYSCALLS - 1), '1);

    // Unbound process, then a save that switches monitoring off until rewritten.
    drain;
    write_reg(CFG_PROCESS_ASSOCIATED, CFG_DATA_W'(1'b0));
    send_call(5, 60);
    drain;
    write_reg(CFG_PROCESS_ASSOCIATED, CFG_DATA_W'(1'b1));
    write_reg(CFG_SAVE_IN_PROGRESS, CFG_DATA_W'(1'b1));
    send_call(6, 61);
    drain;
    write_reg(CFG_SAVE_IN_PROGRESS, CFG_DATA_W'(1'b0));
    write_reg(CFG_SPARE_IDX, '1);
    send_call(7, 62);

    clock_ns = 100;
    setup_profile(1'b1, 1'b0, 1'b1, RST_ANOMALY_LIMIT, RST_NORMAL_FACTOR, 0, 100);
    run_traffic(110, 5, 20);
    setup_profile(1'b1, 1'b0, 1'b1, 0, 1, 1023, 0);
    run_traffic(110, 10, 20);
    setup_profile(1'b1, 1'b0, 1'b1, 16'hFFFF, 1023, 1, 50);
    run_traffic(100, 3, 20);

    steady = 1'b1;
    setup_profile(1'b1, 1'b0, 1'b1, 3, 2, 8, 200);
    run_traffic(120, 4, 30);
    steady = 1'b0;

    setup_profile(1'b1, 1'b0, 1'b1, 5, 1, 4, 30);
    squeeze_req = 1'b1;
    run_traffic(120, 6, 20);

    setup_profile(1'b1, 1'b0, 1'b0, 5, 1, 4, 30);
    run_traffic(8, 10, 20);

    // Deadlines near the top of the time range saturate.
    clock_ns = 64'hFFFF_FFFF_FFFF_F000;
    setup_profile(1'b1, 1'b0, 1'b1, 1, 3, 5, WAIT_MAX);
    run_traffic(100, 4, 30);

    clock_ns = {$urandom, $urandom};
    setup_profile(1'b1, 1'b0, 1'b1, LIMIT_W'($urandom_range(0, 20)), 0,
                  FACTOR_W'($urandom_range(1, 1023)), WAIT_W'($urandom_range(0, 500)));
    run_traffic(120, 3, 20);
    setup_profile(RST_MONITOR_ENABLE, RST_SAVE_IN_PROGRESS, RST_PROCESS_ASSOCIATED,
                  RST_ANOMALY_LIMIT, RST_NORMAL_FACTOR, RST_NORMAL_FACTOR_DEN,
                  RST_NORMAL_WAIT);
    run_traffic(100, 5, 20);

    drain;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
src/slad_pkg.sv
src/slad_ctrl.sv
src/slad_dp.sv
src/syscall_lookahead_anomaly_detector_unit.sv
test/slad_result_check.sv
test/testbench.sv
